// ===== hw/rtl/kcs_pkg.sv =====
// Shared constants, types and state codes for the keyframe curve sampler.
`timescale 1ns / 1ps
package kcs_pkg;
  localparam int MAX_KEYS = 64;
  localparam int KEY_W    = $clog2(MAX_KEYS);
  localparam int CNT_W    = $clog2(MAX_KEYS + 1);
  localparam int COEF_W   = 18;
  localparam int PROD_W   = 33 + COEF_W;
  localparam int ACC_W    = PROD_W + 3;

  localparam logic [1:0] MODE_CONST  = 2'd0;
  localparam logic [1:0] MODE_LINEAR = 2'd1;
  localparam logic [1:0] MODE_CUBIC  = 2'd2;

  localparam logic [1:0] REG_KEY_COUNT   = 2'd0;
  localparam logic [1:0] REG_INTERP_MODE = 2'd1;

  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_SAMPLE = 1'b1;

  typedef logic [2:0][31:0] vec3_t;

  typedef struct packed {
    logic        is_load;
    logic [5:0]  key_index;
    logic [31:0] time_point;
    vec3_t       value;
    vec3_t       in_tan;
    vec3_t       out_tan;
  } item_t;

  typedef enum logic [3:0] {
    S_IDLE, S_FIRST, S_LAST, S_SCAN, S_EDGE, S_DIV,
    S_RD0, S_RD1, S_BASIS, S_MUL, S_ACC, S_OUT
  } back_state_t;
endpackage

// ===== hw/rtl/kcs_front.sv =====
// Front end: accepts transactions, classifies them and queues them for the back end.
`timescale 1ns / 1ps
module kcs_front
  import kcs_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [327:0] s_tdata,
  input  logic         s_tuser,
  output logic         q_valid,
  output item_t        q_item,
  input  logic         q_pop
);
  item_t      entry [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  item_t      incoming;
  logic       push;

  always_comb begin
    incoming.is_load    = (s_tuser == FUNC_LOAD);
    incoming.key_index  = s_tdata[5:0];
    incoming.time_point = s_tdata[37:6];
    incoming.value      = {s_tdata[133:102], s_tdata[101:70], s_tdata[69:38]};
    incoming.in_tan     = {s_tdata[229:198], s_tdata[197:166], s_tdata[165:134]};
    incoming.out_tan    = {s_tdata[325:294], s_tdata[293:262], s_tdata[261:230]};
  end

  assign s_tready = (count != 2'd2);
  assign push     = s_tvalid && s_tready;
  assign q_valid  = (count != 2'd0);
  assign q_item   = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, q_pop};
    end
  end

  a_count_max: assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("queue count out of range");
  a_pop_valid: assert property (@(posedge clk) disable iff (rst) q_pop |-> q_valid)
    else $error("pop from empty queue");
  a_full_hold: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd2 && !q_pop) |=> count == 2'd2)
    else $error("full queue lost an entry");
endmodule

// ===== hw/rtl/kcs_back.sv =====
// Back end: keyframe memories, segment search, fraction divider and interpolation.
`timescale 1ns / 1ps
module kcs_back
  import kcs_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         q_valid,
  input  item_t        q_item,
  output logic         q_pop,
  input  logic [6:0]   key_count,
  input  logic [1:0]   interp_mode,
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [103:0] m_tdata
);
  logic [31:0] time_mem [MAX_KEYS];
  vec3_t       val_mem  [MAX_KEYS];
  vec3_t       itan_mem [MAX_KEYS];
  vec3_t       otan_mem [MAX_KEYS];

  logic [31:0] time_rd;
  vec3_t       val_rd, itan_rd, otan_rd;
  logic [KEY_W-1:0] rd_addr;

  back_state_t state, state_next;

  logic [31:0]       tq;
  logic [CNT_W-1:0]  n;
  logic [KEY_W-1:0]  j, seg;
  logic [31:0]       t0, den;
  logic [32:0]       rem;
  logic [15:0]       quo;
  logic [3:0]        div_cnt;
  logic [31:0]       sq, cube;
  vec3_t             p0, p1, m0, m1;
  logic signed [COEF_W-1:0] coef [4];
  logic [3:0]        term;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  vec3_t             res;

  logic              load_wr;
  logic [32:0]       rem2;
  logic [16:0]       f;
  logic [15:0]       t2, t3;
  logic signed [19:0] h00, h10, h01, h11;
  logic signed [32:0] op_a;
  logic signed [COEF_W-1:0] op_b;
  logic signed [ACC_W-1:0]  acc_sum;
  logic signed [ACC_W-17:0] acc_q;
  logic [31:0]       sat_val;
  logic [CNT_W-1:0]  n_clamp;
  logic [KEY_W-1:0]  last_idx;

  assign load_wr  = (state == S_IDLE) && q_valid && q_item.is_load
                    && ({1'b0, q_item.key_index} < 7'(MAX_KEYS));
  assign n_clamp  = (key_count > 7'(MAX_KEYS)) ? CNT_W'(MAX_KEYS) : CNT_W'(key_count);
  assign last_idx = KEY_W'(n - 1'b1);
  assign rem2     = {rem[31:0], 1'b0};
  assign f        = {1'b0, quo};
  assign t2       = sq[31:16];
  assign t3       = cube[31:16];
  assign h00      = 20'sd65536 + 20'sd2 * $signed({4'd0, t3}) - 20'sd3 * $signed({4'd0, t2});
  assign h10      = $signed({4'd0, t3}) - 20'sd2 * $signed({4'd0, t2}) + $signed({3'd0, f});
  assign h01      = 20'sd3 * $signed({4'd0, t2}) - 20'sd2 * $signed({4'd0, t3});
  assign h11      = $signed({4'd0, t3}) - $signed({4'd0, t2});

  // Memories: one write row per load, one registered read row per cycle.
  always_ff @(posedge clk) begin
    if (load_wr) begin
      time_mem[KEY_W'(q_item.key_index)] <= q_item.time_point;
      val_mem[KEY_W'(q_item.key_index)]  <= q_item.value;
      itan_mem[KEY_W'(q_item.key_index)] <= q_item.in_tan;
      otan_mem[KEY_W'(q_item.key_index)] <= q_item.out_tan;
    end
    time_rd <= time_mem[rd_addr];
    val_rd  <= val_mem[rd_addr];
    itan_rd <= itan_mem[rd_addr];
    otan_rd <= otan_mem[rd_addr];
  end

  // Term operands: the lower value, then tangent or difference, then the upper value and its in tangent.
  always_comb begin
    case (term[1:0])
      2'd0:    op_a = {p0[term[3:2]][31], p0[term[3:2]]};
      2'd1:    op_a = (interp_mode == MODE_LINEAR)
                      ? ($signed({p1[term[3:2]][31], p1[term[3:2]]})
                         - $signed({p0[term[3:2]][31], p0[term[3:2]]}))
                      : {m0[term[3:2]][31], m0[term[3:2]]};
      2'd2:    op_a = {p1[term[3:2]][31], p1[term[3:2]]};
      default: op_a = {m1[term[3:2]][31], m1[term[3:2]]};
    endcase
    op_b    = coef[term[1:0]];
    acc_sum = acc + ACC_W'(prod);
    acc_q   = acc_sum[ACC_W-1:16];
    if (acc_q > $signed((ACC_W-16)'(32'sh7fffffff))) begin
      sat_val = 32'h7fffffff;
    end else if (acc_q < -$signed((ACC_W-16)'(33'sh080000000))) begin
      sat_val = 32'h80000000;
    end else begin
      sat_val = acc_q[31:0];
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (q_valid && !q_item.is_load) begin
          state_next = (n_clamp == '0) ? S_OUT : S_FIRST;
        end
      end
      S_FIRST: state_next = (tq <= time_rd) ? S_EDGE : S_LAST;
      S_LAST:  state_next = (tq >= time_rd) ? S_EDGE : S_SCAN;
      S_SCAN: begin
        if ((t0 <= tq && time_rd > tq) || j == last_idx) begin
          state_next = S_DIV;
        end
      end
      S_EDGE:  state_next = S_OUT;
      S_DIV:   state_next = (div_cnt == 4'd15) ? S_RD0 : S_DIV;
      S_RD0:   state_next = S_RD1;
      S_RD1:   state_next = S_BASIS;
      S_BASIS: state_next = S_MUL;
      S_MUL:   state_next = S_ACC;
      S_ACC:   state_next = (term == 4'd11) ? S_OUT : S_MUL;
      S_OUT:   state_next = m_tready ? S_IDLE : S_OUT;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    q_pop    = (state == S_IDLE) && q_valid;
    m_tvalid = (state == S_OUT);
    m_tdata  = {2'b00, 6'(seg), res[2], res[1], res[0]};
    case (state)
      S_IDLE:  rd_addr = '0;
      S_FIRST: rd_addr = (tq <= time_rd) ? '0 : last_idx;
      S_LAST:  rd_addr = (tq >= time_rd) ? last_idx : KEY_W'(1);
      S_SCAN:  rd_addr = j + 1'b1;
      S_DIV:   rd_addr = seg;
      S_RD0:   rd_addr = seg + 1'b1;
      default: rd_addr = seg;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        tq  <= q_item.time_point;
        n   <= n_clamp;
        seg <= '0;
        res <= '0;
      end
      S_FIRST: begin
        t0  <= time_rd;
        seg <= '0;
      end
      S_LAST: begin
        seg <= (tq >= time_rd) ? last_idx : '0;
        j   <= KEY_W'(1);
      end
      S_SCAN: begin
        if ((t0 <= tq && time_rd > tq) || j == last_idx) begin
          seg     <= j - 1'b1;
          rem     <= {1'b0, tq - t0};
          den     <= time_rd - t0;
          div_cnt <= '0;
        end else begin
          t0 <= time_rd;
          j  <= j + 1'b1;
        end
      end
      S_EDGE: res <= val_rd;
      S_DIV: begin
        if (rem2 >= {1'b0, den}) begin
          rem <= rem2 - {1'b0, den};
          quo <= {quo[14:0], 1'b1};
        end else begin
          rem <= rem2;
          quo <= {quo[14:0], 1'b0};
        end
        div_cnt <= div_cnt + 1'b1;
      end
      S_RD0: begin
        p0 <= val_rd;
        m0 <= otan_rd;
        sq <= {15'd0, f} * {15'd0, f};
      end
      S_RD1: begin
        p1   <= val_rd;
        m1   <= itan_rd;
        cube <= {16'd0, t2} * {15'd0, f};
      end
      S_BASIS: begin
        term <= '0;
        acc  <= '0;
        case (interp_mode)
          MODE_CONST: begin
            coef[0] <= COEF_W'(65536);
            coef[1] <= '0;
            coef[2] <= '0;
            coef[3] <= '0;
          end
          MODE_LINEAR: begin
            coef[0] <= COEF_W'(65536);
            coef[1] <= $signed({1'b0, f});
            coef[2] <= '0;
            coef[3] <= '0;
          end
          MODE_CUBIC: begin
            coef[0] <= h00[COEF_W-1:0];
            coef[1] <= h10[COEF_W-1:0];
            coef[2] <= h01[COEF_W-1:0];
            coef[3] <= h11[COEF_W-1:0];
          end
          default: begin
            coef[0] <= '0;
            coef[1] <= '0;
            coef[2] <= '0;
            coef[3] <= '0;
          end
        endcase
      end
      S_MUL: prod <= op_a * op_b;
      S_ACC: begin
        term <= term + 1'b1;
        if (term[1:0] == 2'd3) begin
          res[term[3:2]] <= sat_val;
          acc            <= '0;
        end else begin
          acc <= acc_sum;
        end
      end
      default: ;
    endcase
  end

  a_div_den: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> den != '0)
    else $error("divider entered with zero segment length");
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> state == S_IDLE)
    else $error("queue popped while busy");
  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> ({1'b0, j} < n))
    else $error("segment search ran past the last key");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> m_tvalid && $stable(res))
    else $error("result changed while stalled");
endmodule

// ===== hw/rtl/keyframe_curve_sampler.sv =====
// Top level of the keyframe curve sampler: configuration registers and the two halves.
// A load is written when the idle back end takes it from the queue; a sample result
// goes straight out for an empty table, after the first or last key check at the table
// ends, and in segment s after s + 1 search, 16 divider and 24 multiply-accumulate steps.
// Throughput: one item at a time in the back end, next item taken after the result transaction.
// Reset (rst, synchronous): key_count 0, interp_mode linear, queue and sequencer empty.
`timescale 1ns / 1ps
module keyframe_curve_sampler
  import kcs_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // key_index, time_point, value_x/y/z, in_tan_x/y/z, out_tan_x/y/z, zero pad
  input  logic [327:0] s_tdata,
  // func
  input  logic         s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // out_x, out_y, out_z, segment_index, zero pad
  output logic [103:0] m_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [6:0]   cfg_data
);
  logic [6:0] key_count;
  logic [1:0] interp_mode;
  logic       q_valid, q_pop;
  item_t      q_item;

  // Config always taken; user must let it arrive only while the block is idle, unchecked.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_count   <= 7'd0;
      interp_mode <= MODE_LINEAR;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_KEY_COUNT:   key_count   <= cfg_data;
        REG_INTERP_MODE: interp_mode <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  kcs_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  kcs_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop),
    .key_count   (key_count),
    .interp_mode (interp_mode),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata)
  );
endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for the keyframe curve sampler: keyframe loads, samples, all modes.
`timescale 1ns / 1ps
module tb_top;
  import kcs_pkg::*;

  // One input transaction as the testbench sees it, before packing onto the bus.
  typedef struct {
    logic        func;
    logic [5:0]  key;
    logic [31:0] tpoint;
    logic [31:0] val [3];
    logic [31:0] itan [3];
    logic [31:0] otan [3];
  } key_item_t;

  typedef struct {
    logic [31:0] v [3];
    logic [5:0]  seg;
  } sample_t;

  localparam int SETTLE_CYCLES = 150;
  localparam int CYCLE_LIMIT   = 400000;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [327:0] s_tdata = '0;
  logic         s_tuser = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [103:0] m_tdata;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [1:0]   cfg_index = '0;
  logic [6:0]   cfg_data = '0;

  keyframe_curve_sampler u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow copy of the keyframe table and registers, updated in transaction order.
  logic [31:0] key_times [MAX_KEYS];
  logic [31:0] key_vals  [3*MAX_KEYS];
  logic [31:0] key_itans [3*MAX_KEYS];
  logic [31:0] key_otans [3*MAX_KEYS];
  int unsigned shadow_count = 0;
  logic [1:0]  shadow_mode  = MODE_LINEAR;

  key_item_t pending_items [$];
  sample_t   expected_samples [$];
  int        in_idle_pct = 22;
  int        out_idle_pct = 71;
  bit        in_taken = 1'b0;
  int        errors = 0;
  int        cycles = 0;
  int        samples_seen = 0;
  int        loads_sent = 0;

  function automatic longint fl16(input longint x);
    return x >>> 16;
  endfunction

  function automatic logic [31:0] sat32(input longint x);
    if (x > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (x < -64'sd2147483648) return 32'h8000_0000;
    return x[31:0];
  endfunction

  // Applies a load to the shadow table, or evaluates the curve for a sample.
  function automatic void apply_to_curve(input key_item_t it);
    sample_t     r;
    int unsigned n, seg, k;
    longint      f, t2, t3, h00, h10, h01, h11, p0, p1, m0, m1, acc;
    longint unsigned t0, t1, tq;
    if (it.func == FUNC_LOAD) begin
      key_times[it.key] = it.tpoint;
      for (int c = 0; c < 3; c++) begin
        key_vals[it.key*3+c]  = it.val[c];
        key_itans[it.key*3+c] = it.itan[c];
        key_otans[it.key*3+c] = it.otan[c];
      end
      return;
    end
    n = (shadow_count > MAX_KEYS) ? MAX_KEYS : shadow_count;
    tq = it.tpoint;
    if (n == 0) begin
      r.v = '{0, 0, 0};
      r.seg = '0;
    end else if (tq <= key_times[0] || tq >= key_times[n-1]) begin
      // Clamped to the first or the last key.
      k = (tq <= key_times[0]) ? 0 : n - 1;
      for (int c = 0; c < 3; c++) r.v[c] = key_vals[k*3+c];
      r.seg = k[5:0];
    end else begin
      seg = 0;
      for (int i = 0; i + 1 < n; i++) begin
        if (key_times[i] <= tq && key_times[i+1] > tq) begin
          seg = i;
          break;
        end
      end
      t0 = key_times[seg];
      t1 = key_times[seg+1];
      f = 0;
      if (t1 > t0 && tq >= t0) f = longint'(((tq - t0) << 16) / (t1 - t0));
      if (f > 65535) f = 65535;
      t2 = fl16(f * f);
      t3 = fl16(t2 * f);
      h00 = 2 * t3 - 3 * t2 + 65536;
      h10 = t3 - 2 * t2 + f;
      h01 = -2 * t3 + 3 * t2;
      h11 = t3 - t2;
      for (int c = 0; c < 3; c++) begin
        p0 = longint'($signed(key_vals[seg*3+c]));
        p1 = longint'($signed(key_vals[(seg+1)*3+c]));
        m0 = longint'($signed(key_otans[seg*3+c]));
        m1 = longint'($signed(key_itans[(seg+1)*3+c]));
        case (shadow_mode)
          MODE_CONST:  acc = p0;
          MODE_LINEAR: acc = p0 + fl16((p1 - p0) * f);
          MODE_CUBIC:  acc = fl16(p0 * h00 + m0 * h10 + p1 * h01 + m1 * h11);
          default:     acc = 0;
        endcase
        r.v[c] = sat32(acc);
      end
      r.seg = seg[5:0];
    end
    expected_samples.insert(expected_samples.size(), r);
  endfunction

  // Sampling side: accepts transactions, feeds the predictor and checks results.
  always @(posedge clk) begin
    sample_t exp_r;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_top NOT OK");
      $finish;
    end else begin
      in_taken = s_tvalid && s_tready;
      if (in_taken) apply_to_curve(pending_items.pop_front());
      if (m_tvalid && m_tready) begin
        samples_seen++;
        if (expected_samples.size() == 0) begin
          $display("%0t: unexpected result, actual %h", $time, m_tdata);
          errors++;
        end else begin
          exp_r = expected_samples.pop_front();
          for (int c = 0; c < 3; c++) begin
            if (m_tdata[c*32 +: 32] !== exp_r.v[c]) begin
              $display("%0t: component %0d expected %h actual %h", $time, c, exp_r.v[c],
                       m_tdata[c*32 +: 32]);
              errors++;
            end
          end
          if (m_tdata[101:96] !== exp_r.seg) begin
            $display("%0t: segment_index expected %0d actual %0d", $time, exp_r.seg,
                     m_tdata[101:96]);
            errors++;
          end
        end
      end
    end
  end

  // Driving side: valid is held until taken, ready toggles at random.
  always @(negedge clk) begin
    key_item_t it;
    if (!rst) begin
      if (!s_tvalid || in_taken) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= in_idle_pct) begin
          it = pending_items[0];
          s_tvalid <= 1'b1;
          s_tuser  <= it.func;
          // Fields from the lowest bit up: key, time, value, in tangent, out tangent.
          s_tdata  <= {2'b00, it.otan[2], it.otan[1], it.otan[0], it.itan[2], it.itan[1],
                       it.itan[0], it.val[2], it.val[1], it.val[0], it.tpoint, it.key};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
      m_tready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  function automatic logic [31:0] pick_value();
    case ($urandom_range(7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'(int'($urandom_range(0, 2000000)) - 1000000);
      default: return $urandom;
    endcase
  endfunction

  function automatic key_item_t make_load(input logic [5:0] k, input logic [31:0] t);
    key_item_t it;
    it.func = FUNC_LOAD;
    it.key = k;
    it.tpoint = t;
    for (int c = 0; c < 3; c++) begin
      it.val[c]  = pick_value();
      it.itan[c] = pick_value();
      it.otan[c] = pick_value();
    end
    return it;
  endfunction

  // Sample items carry random bits in the unused fields.
  function automatic key_item_t make_sample(input logic [31:0] t);
    key_item_t it;
    it = make_load(6'($urandom), t);
    it.func = FUNC_SAMPLE;
    return it;
  endfunction

  task automatic queue_load(input logic [5:0] k, input logic [31:0] t);
    pending_items.insert(pending_items.size(), make_load(k, t));
    loads_sent++;
  endtask

  task automatic queue_sample(input logic [31:0] t);
    pending_items.insert(pending_items.size(), make_sample(t));
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [6:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_KEY_COUNT) shadow_count = val;
    else if (idx == REG_INTERP_MODE) shadow_mode = val[1:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Registers change only once the block has drained and a load could have finished.
  task automatic set_regs(input logic [6:0] count, input logic [1:0] mode);
    wait (pending_items.size() == 0 && !s_tvalid && expected_samples.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(REG_KEY_COUNT, count);
    write_reg(REG_INTERP_MODE, mode);
  endtask

  initial begin
    logic [31:0]  t;
    int unsigned  n;
    logic [6:0]   cnt;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part: empty table at reset, then four keys spanning the whole time range.
    queue_sample(32'h0000_1234);
    queue_load(6'd0, 32'h0000_0000);
    queue_load(6'd1, 32'h0000_0100);
    queue_load(6'd2, 32'h8000_0000);
    queue_load(6'd3, 32'hFFFF_FFFF);
    queue_load(6'd63, 32'hFFFF_FFFF);
    set_regs(7'd4, MODE_CUBIC);
    queue_sample(32'h0000_0000);
    queue_sample(32'h0000_0080);
    queue_sample(32'h0000_0100);
    queue_sample(32'h7FFF_FFFF);
    queue_sample(32'hFFFF_FFFE);
    queue_sample(32'hFFFF_FFFF);
    set_regs(7'd4, MODE_CONST);
    queue_sample(32'h4000_0000);
    queue_sample(32'h0000_00FF);
    set_regs(7'd4, 2'd3);  // Reserved mode yields a zero vector inside a segment.
    queue_sample(32'h4000_0000);
    queue_sample(32'h0000_0000);
    set_regs(7'd1, MODE_LINEAR);
    queue_sample(32'h0000_0000);
    queue_sample(32'h8000_0000);
    set_regs(7'd4, MODE_LINEAR);
    queue_sample(32'h9000_0000);
    queue_sample(32'h0000_0001);

    // Fill the whole table with rising key times so that any key count is safe to use.
    t = $urandom_range(0, 1000);
    for (int k = 0; k < MAX_KEYS; k++) begin
      queue_load(6'(k), t);
      t = t + $urandom_range(1, 1 << 25);
    end

    for (int ph = 0; ph < 12; ph++) begin
      if (ph == 4) begin
        in_idle_pct = 71;
        out_idle_pct = 22;
      end else if (ph == 8) begin
        in_idle_pct = 0;
        out_idle_pct = 0;
      end
      case (ph)
        0: cnt = 7'd64;
        1: cnt = 7'd127;
        2: cnt = 7'd2;
        5: cnt = 7'd0;
        default: cnt = 7'($urandom_range(2, 100));
      endcase
      set_regs(cnt, 2'(ph % 4));
      n = (cnt > MAX_KEYS) ? MAX_KEYS : cnt;
      for (int i = 0; i < 30; i++) begin
        if ($urandom_range(99) < 12) begin
          // Mostly new values at the old time; sometimes a random time breaks the order.
          t = $urandom_range(0, MAX_KEYS - 1);
          queue_load(t[5:0], ($urandom_range(9) == 0) ? $urandom : key_times[t[5:0]]);
        end else if (n > 1 && $urandom_range(9) != 0) begin
          queue_sample(key_times[0] + $urandom_range(0, key_times[n-1] - key_times[0]));
        end else begin
          queue_sample($urandom);
        end
      end
    end

    wait (pending_items.size() == 0 && !s_tvalid && expected_samples.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d keyframe loads; checked %0d curve samples over constant, linear,",
             loads_sent, samples_seen);
    $display("cubic and reserved modes with key counts from empty to beyond the table size.");
    if (errors == 0 && expected_samples.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
hw/rtl/kcs_pkg.sv
hw/rtl/kcs_front.sv
hw/rtl/kcs_back.sv
hw/rtl/keyframe_curve_sampler.sv
sim/tb_top.sv
